>>> hdl/bpj_pkg.sv
// Shared types, constants and helpers of the bitplane to pixel index joiner.
`default_nettype none

package bpj_pkg;

    // Field and counter widths fixed by the frame format
    localparam int POS_W       = 13;     // byte position within one plane
    localparam int TOTAL_W     = 14;     // data bytes seen in a frame
    localparam int PROD_W      = 16;     // width * height
    localparam int WIDTH_W     = 9;
    localparam int HEIGHT_W    = 7;
    localparam int PCOUNT_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int GROUP_W     = 32;     // eight 4-bit indices
    localparam int OUT_POS_W   = 11;
    localparam int INDEX_BITS  = 4;      // bits per pixel index
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;

    localparam logic [TOTAL_W-1:0] COUNT_MAX = {TOTAL_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 9'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd64;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 3'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PLANE_COUNT  = 2'd2
    } cfg_index_t;

    // Input action and result kind codes
    localparam logic ACT_DATA     = 1'b0;
    localparam logic ACT_EOF      = 1'b1;
    localparam logic KIND_GROUP   = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Transaction held between the counter stage and the store update
    typedef struct packed {
        logic             status;   // end-of-frame status
        logic             ok;       // frame size matched
        logic             write;    // updates the store
        logic             emit;     // last plane: result goes out
        logic             first;    // plane 0 overwrites the entry
        logic [POS_W-1:0] pos;
        logic [GROUP_W-1:0] bits;   // plane bits already spread
    } stage_t;

    // Place bit i of a plane byte at bit 4*i+lane of a pixel group
    function automatic logic [GROUP_W-1:0] spread_bits(input logic [7:0] plane_byte,
                                                       input logic [1:0] lane);
        logic [GROUP_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[INDEX_BITS*i + int'(lane)] = plane_byte[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bpj_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bpj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                                           clk,
    input  wire                                           wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  wire  [WIDTH-1:0]                              wr_data,
    input  wire                                           rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/bitplane_to_pixel_index_joiner.sv
// Top level: joins planar bitplane bytes into 4-bit pixel indices per byte position.
//
// Input stream s_*: one transaction per plane byte (s_tuser = 0, byte in s_tdata)
// or an end of frame (s_tuser = 1). Bytes come plane by plane; the plane size is
// frame_width*frame_height/8. Bytes past planes*plane_size are counted, not stored.
// Output stream m_*: while the final plane arrives, one pixel group per stored byte
// (m_tuser = 0) with its position and eight indices; each end of frame gives one
// status (m_tuser = 1) whose frame_ok says whether the byte count matched.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata, to be written only while no
// transaction is in flight; the block itself does not enforce this.
// Path: an accepted transaction passes the store stage and then the output register.
// Throughput: one transaction per cycle unless stalled; per byte the store takes one
// read-modify-write (read at acceptance, write in the store stage, with forwarding).
// Stall: a result waits in the output register; s_tready drops only when a
// result is waiting there unaccepted and another result is right behind it.
// Reset: counters clear, configuration returns to 256 x 64 with 4 planes; the
// store is not cleared, plane 0 overwrites each entry in every frame.
`default_nettype none

module bitplane_to_pixel_index_joiner #(
    parameter int GROUP_DEPTH = 2048,
    parameter int MAX_PLANES  = 4
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // s_tdata: plane_byte[7:0]
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [bpj_pkg::IN_DATA_W-1:0]        s_tdata,
    // s_tuser: action[0]
    input  wire  [0:0]                           s_tuser,
    // m_tdata: group_position[10:0], pixel_indices[42:11], frame_ok[43], zeros[47:44]
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [bpj_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser: result_kind[0]
    output logic [0:0]                           m_tuser,
    input  wire                                  cfg_wr_en,
    input  wire  [bpj_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [bpj_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import bpj_pkg::*;

    localparam int PW    = $clog2(MAX_PLANES + 1);
    localparam int AW    = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int EXP_W = POS_W + PW;
    localparam int CMP_W = EXP_W + 2;

    function automatic logic [PW-1:0] clamp_planes(input logic [PCOUNT_W-1:0] raw);
        if (raw == '0) begin
            return PW'(1);
        end else if (int'(raw) > MAX_PLANES) begin
            return PW'(MAX_PLANES);
        end else begin
            return PW'(raw);
        end
    endfunction

    // Configuration state
    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [POS_W-1:0]    size_reg;
    logic [PW-1:0]       planes_reg;

    // Frame counters
    logic [POS_W-1:0]    byte_position_reg, byte_position_next;
    logic [PW-1:0]       plane_number_reg, plane_number_next;
    logic [TOTAL_W-1:0]  byte_total_reg, byte_total_next;

    // Stage between store read and store write
    stage_t              s1_reg, s1_next;
    logic                s1_valid_reg;

    // Forwarding of the latest store write
    logic                fwd_valid_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic [GROUP_W-1:0]  fwd_data_reg;

    // Output register
    logic                m_valid_reg;
    logic                m_kind_reg;
    logic                m_ok_reg;
    logic [OUT_POS_W-1:0] m_pos_reg;
    logic [GROUP_W-1:0]  m_pix_reg;

    logic                accept;
    logic                is_eof;
    logic [EXP_W-1:0]    expected;
    logic                in_frame;
    logic                in_store;
    logic                do_write;
    logic                last_plane;
    logic                frame_ok;
    logic [POS_W:0]      pos_inc;
    logic                wrap;
    logic [GROUP_W-1:0]  plane_bits;

    logic                ram_rd_en;
    logic                ram_we;
    logic [GROUP_W-1:0]  ram_rdata;
    logic                fwd_hit;
    logic [GROUP_W-1:0]  old_group;
    logic [GROUP_W-1:0]  group;
    logic                s1_result;
    logic                advance;

    // Configuration writes; the plane size multiply is registered here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
            size_reg         <= POS_W'((PROD_W'(WIDTH_RST) * PROD_W'(HEIGHT_RST)) >> 3);
            planes_reg       <= clamp_planes(PCOUNT_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wdata[WIDTH_W-1:0];
                    size_reg <= POS_W'((PROD_W'(cfg_wdata[WIDTH_W-1:0])
                                        * PROD_W'(frame_height_reg)) >> 3);
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                    size_reg <= POS_W'((PROD_W'(frame_width_reg)
                                        * PROD_W'(cfg_wdata[HEIGHT_W-1:0])) >> 3);
                end
                CFG_PLANE_COUNT: begin
                    planes_reg <= clamp_planes(cfg_wdata[PCOUNT_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Acceptance and frame bookkeeping
    assign accept     = s_tvalid && s_tready;
    assign is_eof     = (s_tuser[0] == ACT_EOF);
    assign expected   = EXP_W'(size_reg) * EXP_W'(planes_reg);
    assign in_frame   = (CMP_W'(byte_total_reg) < CMP_W'(expected))
                        && (plane_number_reg < planes_reg);
    assign in_store   = ((POS_W + 1)'(byte_position_reg) < (POS_W + 1)'(GROUP_DEPTH));
    assign do_write   = in_frame && in_store;
    assign last_plane = ((PW + 1)'(plane_number_reg) + (PW + 1)'(1)) == (PW + 1)'(planes_reg);
    assign frame_ok   = (CMP_W'(byte_total_reg) >= CMP_W'(expected))
                        && (CMP_W'(byte_total_reg) < CMP_W'(expected) + CMP_W'(planes_reg));
    assign pos_inc    = (POS_W + 1)'(byte_position_reg) + (POS_W + 1)'(1);
    assign wrap       = pos_inc >= (POS_W + 1)'(size_reg);
    assign plane_bits = (int'(plane_number_reg) < INDEX_BITS)
                        ? spread_bits(s_tdata, 2'(plane_number_reg)) : '0;

    always_comb begin
        byte_position_next = byte_position_reg;
        plane_number_next  = plane_number_reg;
        byte_total_next    = byte_total_reg;
        if (accept) begin
            if (is_eof) begin
                byte_position_next = '0;
                plane_number_next  = '0;
                byte_total_next    = '0;
            end else begin
                if (byte_total_reg != COUNT_MAX) begin
                    byte_total_next = byte_total_reg + TOTAL_W'(1);
                end
                if (in_frame) begin
                    if (wrap) begin
                        byte_position_next = '0;
                        plane_number_next  = plane_number_reg + PW'(1);
                    end else begin
                        byte_position_next = pos_inc[POS_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= '0;
            plane_number_reg  <= '0;
            byte_total_reg    <= '0;
        end else begin
            byte_position_reg <= byte_position_next;
            plane_number_reg  <= plane_number_next;
            byte_total_reg    <= byte_total_next;
        end
    end

    // Transaction entering the store stage
    always_comb begin
        s1_next        = '0;
        s1_next.status = is_eof;
        s1_next.ok     = frame_ok;
        s1_next.write  = !is_eof && do_write;
        s1_next.emit   = !is_eof && do_write && last_plane;
        s1_next.first  = (plane_number_reg == '0);
        s1_next.pos    = byte_position_reg;
        s1_next.bits   = plane_bits;
    end

    // Read of the entry happens at acceptance; plane 0 needs no read
    assign ram_rd_en = accept && !is_eof && do_write && (plane_number_reg != '0);

    bpj_ram #(
        .WIDTH (GROUP_W),
        .DEPTH (GROUP_DEPTH)
    ) u_groups (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_reg.pos[AW-1:0]),
        .wr_data (group),
        .rd_en   (ram_rd_en),
        .rd_addr (byte_position_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Modify: merge plane bits, forwarding a write that raced the read
    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s1_reg.pos[AW-1:0]);
    assign old_group = fwd_hit ? fwd_data_reg : ram_rdata;
    assign group     = s1_reg.first ? s1_reg.bits : (old_group | s1_reg.bits);

    // Flow control
    assign s1_result = s1_valid_reg && (s1_reg.status || s1_reg.emit);
    assign advance   = !s1_result || !m_valid_reg || m_tready;
    assign s_tready  = advance;
    assign ram_we    = s1_valid_reg && s1_reg.write && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ram_we) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_addr_reg <= s1_reg.pos[AW-1:0];
            fwd_data_reg <= group;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && s1_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_result) begin
            m_kind_reg <= s1_reg.status ? KIND_STATUS : KIND_GROUP;
            m_ok_reg   <= s1_reg.status && s1_reg.ok;
            m_pos_reg  <= s1_reg.status ? '0 : s1_reg.pos[OUT_POS_W-1:0];
            m_pix_reg  <= s1_reg.status ? '0 : group;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_POS_W - GROUP_W - 1)'(0), m_ok_reg, m_pix_reg, m_pos_reg};

    // Input is held back only behind a waiting result
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without a waiting result");

    // Store writes stay inside the memory
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((POS_W + 1)'(s1_reg.pos) < (POS_W + 1)'(GROUP_DEPTH)))
        else $error("store write beyond its depth");

    // A pixel group only comes from a byte that updates the store
    a_emit_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_reg.emit) |-> (s1_reg.write && !s1_reg.status))
        else $error("pixel group without store update");

    // A stalled store stage keeps its transaction
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("store stage changed while stalled");

endmodule

`default_nettype wire
